// ===== design/lss_pkg.sv =====
// Shared types and constants for the LIFO stack with search.
// No dependencies; imported by the interfaces and all modules but lss_ram.
`timescale 1ns / 1ps

package lss_pkg;

  localparam int unsigned DepthDef = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PosW     = 6;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_SHOW   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // One result beat as it travels from the sequencer to the output stage.
  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] data;
    logic [PosW-1:0]         position;
    logic                    last;
  } res_t;

endpackage

// ===== design/lss_if.sv =====
// Valid/ready channel interfaces: request (kind, value) and response.
// Depends on lss_pkg for field widths.
`timescale 1ns / 1ps

interface lss_req_if import lss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KindW-1:0]        kind;
  logic signed [DataW-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface lss_rsp_if import lss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] data;
  logic [PosW-1:0]         position;
  logic                    last;

  modport source (output valid, status, data, position, last, input ready);
  modport sink   (input valid, status, data, position, last, output ready);
endinterface

// ===== design/lss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lss_out_reg.sv =====
// Output register stage: holds one result beat until the sink takes it.
// Depends on lss_pkg (res_t) and lss_rsp_if.
`timescale 1ns / 1ps

module lss_out_reg import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_t      res_i,
  output logic      free_o,
  lss_rsp_if.source rsp_o
);

  logic out_v_q, out_v_d;
  res_t res_q;

  assign free_o = !out_v_q || rsp_o.ready;

  always_comb begin
    out_v_d = out_v_q;
    if (load_i) begin
      out_v_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign rsp_o.valid    = out_v_q;
  assign rsp_o.status   = res_q.status;
  assign rsp_o.data     = res_q.data;
  assign rsp_o.position = res_q.position;
  assign rsp_o.last     = res_q.last;

  // Loading is only legal into a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> free_o)
    else $error("lss_out_reg: load while slot occupied");

endmodule

// ===== design/lss_top.sv =====
// Bounded LIFO stack with search and show.
// The stack lives in a DEPTH-entry RAM with registered read data, and every
// result passes through a one-beat output register. A push writes the RAM
// directly; a pop first reads the top entry from the RAM. Search reads one
// entry per cycle from the top and examines at most the fill count of
// entries. Show emits one beat per cycle from top to bottom, stretched by
// any backpressure on the response side. Push/pop/error results occupy a
// single beat. One item is in flight at a time; the next request is taken
// once the current item's last beat sits in the output register. Stack
// contents are not cleared at reset; only the fill count is.
// Depends on lss_pkg, lss_if, lss_ram and lss_out_reg.
`timescale 1ns / 1ps

module lifo_stack_with_search_top import lss_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lss_req_if.sink req_i,
  lss_rsp_if.source rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POPRD = 4'b0010,
    S_WALK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         raddr_q, raddr_d;
  logic [PosW-1:0]       d_q, d_d;
  kind_e                 kind_q, kind_d;
  logic [DataW-1:0]      key_q, key_d;
  res_t                  res_q, res_d;

  logic                  req_fire;
  logic                  ram_we, ram_re;
  logic [DataW-1:0]      rdata;
  logic                  full, empty;
  logic                  slot_free;
  logic                  out_load;
  res_t                  out_res;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign full        = (cnt_q == CW'(DEPTH));
  assign empty       = (cnt_q == '0);

  lss_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (req_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr_d),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    raddr_d  = raddr_q;
    d_d      = d_q;
    kind_d   = kind_q;
    key_d    = key_q;
    res_d    = res_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    out_res  = res_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          kind_d = kind_e'(req_i.kind);
          key_d  = req_i.value;
          d_d    = '0;
          res_d  = '{status: ST_OK, data: '0, position: '0, last: 1'b1};
          state_d = S_EMIT;
          case (kind_e'(req_i.kind))
            KIND_PUSH: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            KIND_POP: begin
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                raddr_d = AW'(cnt_q - CW'(1));
                cnt_d   = cnt_q - CW'(1);
                state_d = S_POPRD;
              end
            end
            default: begin
              // search and show both walk from the top entry down
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                raddr_d = AW'(cnt_q - CW'(1));
                state_d = S_WALK;
              end
            end
          endcase
        end
      end
      S_POPRD: begin
        res_d.data = rdata;
        state_d    = S_EMIT;
      end
      S_WALK: begin
        if (kind_q == KIND_SHOW) begin
          if (slot_free) begin
            out_load = 1'b1;
            out_res  = '{status: ST_OK, data: rdata, position: d_q,
                         last: (raddr_q == '0)};
            if (raddr_q == '0) begin
              state_d = S_IDLE;
            end else begin
              ram_re  = 1'b1;
              raddr_d = raddr_q - AW'(1);
              d_d     = d_q + PosW'(1);
            end
          end
        end else begin
          if (rdata == key_q) begin
            res_d   = '{status: ST_OK, data: rdata, position: d_q, last: 1'b1};
            state_d = S_EMIT;
          end else if (raddr_q == '0) begin
            res_d   = '{status: ST_NOTFOUND, data: '0, position: '0, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            ram_re  = 1'b1;
            raddr_d = raddr_q - AW'(1);
            d_d     = d_q + PosW'(1);
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      raddr_q <= '0;
      d_q     <= '0;
      kind_q  <= KIND_PUSH;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      raddr_q <= raddr_d;
      d_q     <= d_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  lss_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (out_res),
    .free_o (slot_free),
    .rsp_o  (rsp_o)
  );

  // Fill count never exceeds the stack bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("lss: fill count above DEPTH");

  // A push into a full stack leaves the fill count alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_i.kind == KIND_PUSH) && full |=> $stable(cnt_q))
    else $error("lss: push on full stack changed fill count");

  // The walk only touches entries below the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (CW'(raddr_q) < cnt_q))
    else $error("lss: walk address outside stack");

  // A pop moves the fill count down by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_i.kind == KIND_POP) && !empty |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("lss: pop did not decrement fill count");

endmodule

// ===== tb/sv/lss_checker.sv =====
// Scoreboard for the LIFO stack: watches both channels, keeps its own stack
// image, predicts every response beat and compares field by field.
// Depends on lss_pkg and lss_if.
`timescale 1ns / 1ps

module lss_checker import lss_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lss_req_if          req_i,
  lss_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [DataW-1:0] stack_img [DEPTH];
  int unsigned      stack_level;
  res_t             beats_due [$];
  int unsigned      n_fail = 0;
  int unsigned      n_due = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_due;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: stack mismatch: %s", $time, msg);
    n_fail++;
  endtask

  function automatic void expect_beat(input status_e st, input logic [DataW-1:0] word,
                                      input logic [PosW-1:0] pos, input logic fin);
    res_t beat;
    beat.status   = st;
    beat.data     = word;
    beat.position = pos;
    beat.last     = fin;
    beats_due.push_back(beat);
  endfunction

  task automatic predict_stack_op(input kind_e kind, input logic [DataW-1:0] value);
    bit hit;
    hit = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (stack_level >= DEPTH) begin
          expect_beat(ST_FULL, '0, '0, 1'b1);
        end else begin
          stack_img[stack_level] = value;
          stack_level++;
          expect_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      KIND_POP: begin
        if (stack_level == 0) begin
          expect_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          stack_level--;
          expect_beat(ST_OK, stack_img[stack_level], '0, 1'b1);
        end
      end
      KIND_SEARCH: begin
        if (stack_level == 0) begin
          expect_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // first match counting down from the top wins
          for (int unsigned d = 0; d < stack_level; d++) begin
            if (!hit && stack_img[stack_level - 1 - d] == value) begin
              expect_beat(ST_OK, value, PosW'(d), 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            expect_beat(ST_NOTFOUND, '0, '0, 1'b1);
          end
        end
      end
      default: begin
        if (stack_level == 0) begin
          expect_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned d = 0; d < stack_level; d++) begin
            expect_beat(ST_OK, stack_img[stack_level - 1 - d], PosW'(d),
                        (d + 1 == stack_level));
          end
        end
      end
    endcase
  endtask

  // Request handled before response so a same-edge beat still finds its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      stack_level = 0;
      beats_due.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        predict_stack_op(kind_e'(req_i.kind), req_i.value);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status=%0d data=%h pos=%0d last=%b",
                                    rsp_i.status, rsp_i.data, rsp_i.position, rsp_i.last));
        end else begin
          want = beats_due.pop_front();
          if (rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", rsp_i.status, want.status));
          end
          if (rsp_i.data !== want.data) begin
            report_mismatch($sformatf("data got %h want %h", rsp_i.data, want.data));
          end
          if (rsp_i.position !== want.position) begin
            report_mismatch($sformatf("position got %0d want %0d", rsp_i.position,
                                      want.position));
          end
          if (rsp_i.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", rsp_i.last, want.last));
          end
        end
      end
    end
    n_due = beats_due.size();
  end

endmodule

// ===== tb/sv/tb_lifo_stack_with_search_top.sv =====
// Testbench top for the LIFO stack: clock, reset, request stimulus with
// random gaps, response backpressure and the final verdict.
// Depends on lss_pkg, lss_if, lss_checker and the stack RTL.
`timescale 1ns / 1ps

module tb_lifo_stack_with_search_top;
  import lss_pkg::*;

  localparam int unsigned     RandItems = 230;
  localparam logic [DataW-1:0] WordMin  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] WordMax  = {1'b0, {(DataW-1){1'b1}}};

  typedef enum logic [1:0] {
    GEN_FILL,
    GEN_MIX,
    GEN_DRAIN
  } gen_mode_e;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned fill_est;
  int unsigned quiet_left;

  lss_req_if req_if ();
  lss_rsp_if rsp_if ();

  lifo_stack_with_search_top #(.DEPTH(DepthDef)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lss_checker #(.DEPTH(DepthDef)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (roll < 5) begin
      quiet_left = 20;
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // small pool so searches hit, plus extremes and full-range words
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DataW'($urandom_range(0, 7));
      4: begin
        case ($urandom_range(0, 3))
          0:       return WordMin;
          1:       return WordMax;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic kind_e weighted_kind(input int unsigned w_push, input int unsigned w_pop,
                                          input int unsigned w_search);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < w_push) return KIND_PUSH;
    if (roll < w_push + w_pop) return KIND_POP;
    if (roll < w_push + w_pop + w_search) return KIND_SEARCH;
    return KIND_SHOW;
  endfunction

  task automatic issue(input kind_e kind, input logic [DataW-1:0] value);
    int unsigned gap;
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    if (kind == KIND_PUSH && fill_est < DepthDef) fill_est++;
    if (kind == KIND_POP && fill_est > 0) fill_est--;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // response backpressure: short ready bursts with stalls, sometimes a long open run
  initial begin
    int unsigned run;
    int unsigned stall;
    int unsigned roll;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      run  = ($urandom_range(0, 15) == 0) ? 120 : $urandom_range(1, 10);
      roll = $urandom_range(0, 99);
      if (roll < 60) stall = $urandom_range(0, 2);
      else if (roll < 90) stall = $urandom_range(3, 6);
      else stall = $urandom_range(10, 30);
      @(negedge clk);
      rsp_if.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (stall > 0) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    gen_mode_e   mode;
    gen_mode_e   after_mix;
    int unsigned mix_left;
    int unsigned edge_hits;
    kind_e       kind;
    req_if.valid = 1'b0;
    req_if.kind  = KIND_PUSH;
    req_if.value = '0;
    rst_n        = 1'b0;
    fill_est     = 0;
    quiet_left   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, duplicates, hits at both ends, a miss
    issue(KIND_POP, pick_word());
    issue(KIND_SEARCH, DataW'(5));
    issue(KIND_SHOW, pick_word());
    issue(KIND_PUSH, WordMin);
    issue(KIND_PUSH, WordMax);
    issue(KIND_PUSH, '0);
    issue(KIND_PUSH, '1);
    issue(KIND_PUSH, DataW'(5));
    issue(KIND_PUSH, DataW'(9));
    issue(KIND_PUSH, DataW'(5));
    issue(KIND_SEARCH, DataW'(5));
    issue(KIND_SEARCH, WordMin);
    issue(KIND_SEARCH, WordMax);
    issue(KIND_SEARCH, '1);
    issue(KIND_SEARCH, DataW'(123));
    issue(KIND_SHOW, pick_word());
    issue(KIND_POP, pick_word());
    issue(KIND_POP, pick_word());
    issue(KIND_SEARCH, DataW'(5));
    issue(KIND_SHOW, pick_word());

    // random: fill to the top, mix, drain to empty, mix, and around again
    mode      = GEN_FILL;
    after_mix = GEN_DRAIN;
    mix_left  = 0;
    edge_hits = 0;
    for (int i = 0; i < RandItems; i++) begin
      case (mode)
        GEN_FILL: begin
          if (fill_est < DepthDef) begin
            kind = weighted_kind(80, 4, 12);
          end else if (edge_hits < 3) begin
            kind = KIND_PUSH;
            edge_hits++;
          end else begin
            kind      = KIND_SHOW;
            mode      = GEN_MIX;
            after_mix = GEN_DRAIN;
            mix_left  = 50;
            edge_hits = 0;
          end
        end
        GEN_DRAIN: begin
          if (fill_est > 0) begin
            kind = weighted_kind(4, 80, 12);
          end else if (edge_hits < 2) begin
            kind = weighted_kind(0, 50, 50);
            edge_hits++;
          end else begin
            kind      = KIND_SHOW;
            mode      = GEN_MIX;
            after_mix = GEN_FILL;
            mix_left  = 40;
            edge_hits = 0;
          end
        end
        default: begin
          kind = weighted_kind(35, 30, 25);
          if (mix_left > 0) mix_left--;
          else mode = after_mix;
        end
      endcase
      issue(kind, pick_word());
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * DepthDef + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== lifo_stack_with_search_top.f =====
design/lss_pkg.sv
design/lss_if.sv
design/lss_ram.sv
design/lss_out_reg.sv
design/lss_top.sv
tb/sv/lss_checker.sv
tb/sv/tb_lifo_stack_with_search_top.sv
